// ===== sv/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, codes and sizes of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

	localparam int NUM_ZONES    = 3;
	localparam int NUM_READINGS = 3;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_TAP  = 2'd1;
	localparam logic [1:0] EV_HOLD = 2'd2;
	localparam logic [1:0] EV_PET  = 2'd3;

	localparam logic [7:0] REG_TOUCH_THRESHOLD = 8'd0;
	localparam logic [7:0] REG_HOLD_TIME_MS    = 8'd1;
	localparam logic [7:0] REG_PET_WINDOW_MS   = 8'd2;
	localparam logic [7:0] REG_PET_TAP_COUNT   = 8'd3;

	localparam logic [15:0] RST_TOUCH_THRESHOLD = 16'd40;
	localparam logic [15:0] RST_HOLD_TIME_MS    = 16'd800;
	localparam logic [15:0] RST_PET_WINDOW_MS   = 16'd600;
	localparam logic [3:0]  RST_PET_TAP_COUNT   = 4'd3;

	localparam logic [3:0] RUN_MAX = 4'd15;

	typedef struct packed {
		logic [15:0] touch_threshold;
		logic [15:0] hold_time_ms;
		logic [15:0] pet_window_ms;
		logic [3:0]  pet_tap_count;
	} cfg_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic touch;
	} zone_ctl_t;

endpackage

// ===== sv/tgc_if.sv =====
// ----------------------------------------------------------------------------
// tgc_if
// Valid/ready channels of the touch gesture classifier: items, results and
// register writes.
// ----------------------------------------------------------------------------
interface tgc_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] now_ms;
	logic [15:0] raw_shade;
	logic [15:0] raw_base;
	logic [15:0] raw_arm;
	logic [1:0]  zone_sel;

	modport source (output valid, cmd, now_ms, raw_shade, raw_base, raw_arm, zone_sel,
		input ready);
	modport sink (input valid, cmd, now_ms, raw_shade, raw_base, raw_arm, zone_sel,
		output ready);
endinterface

interface tgc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;

	modport source (output valid, event_res, input ready);
	modport sink (input valid, event_res, output ready);
endinterface

interface tgc_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/touch_gesture_classifier_top.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top
// Tap, hold and pet gesture classifier for capacitive touch zones.
// ----------------------------------------------------------------------------
// The block takes one item per clock. An item is registered, then every zone
// is updated (or the selected zone's event read and cleared) by short compare
// logic as the item leaves the input register; a read result is registered at
// that same edge, and an update gives no result. The output register lets
// items keep flowing while a result waits; only a read that meets a stalled,
// full output register holds the input stage. Registers are written through
// the configuration channel, which is always ready.
module touch_gesture_classifier_top (
	input  logic                clk,
	input  logic                arst_n,
	tgc_cfg_if.sink             cfg,
	tgc_item_if.sink            item,
	tgc_result_if.source        result
);

	tgc_pkg::cfg_t cfg_q;

	logic        valid_s1;
	logic        cmd_s1;
	logic [31:0] now_s1;
	logic [15:0] raw_s1 [tgc_pkg::NUM_READINGS];
	logic [1:0]  sel_s1;

	logic        out_valid_q;
	logic [1:0]  event_q;

	logic        adv;
	logic        is_read;
	logic [1:0]  pend [tgc_pkg::NUM_ZONES];
	logic [1:0]  read_ev;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.touch_threshold <= tgc_pkg::RST_TOUCH_THRESHOLD;
			cfg_q.hold_time_ms    <= tgc_pkg::RST_HOLD_TIME_MS;
			cfg_q.pet_window_ms   <= tgc_pkg::RST_PET_WINDOW_MS;
			cfg_q.pet_tap_count   <= tgc_pkg::RST_PET_TAP_COUNT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tgc_pkg::REG_TOUCH_THRESHOLD: cfg_q.touch_threshold <= cfg.data;
				tgc_pkg::REG_HOLD_TIME_MS:    cfg_q.hold_time_ms    <= cfg.data;
				tgc_pkg::REG_PET_WINDOW_MS:   cfg_q.pet_window_ms   <= cfg.data;
				tgc_pkg::REG_PET_TAP_COUNT:   cfg_q.pet_tap_count   <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	assign is_read    = cmd_s1 == tgc_pkg::CMD_READ;
	assign adv        = valid_s1 && (!is_read || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1    <= item.cmd;
			now_s1    <= item.now_ms;
			raw_s1[0] <= item.raw_shade;
			raw_s1[1] <= item.raw_base;
			raw_s1[2] <= item.raw_arm;
			sel_s1    <= item.zone_sel;
		end
	end

	for (genvar i = 0; i < tgc_pkg::NUM_ZONES; i++) begin : g_zone
		tgc_pkg::zone_ctl_t ctl;
		logic               sel_hit;

		assign sel_hit = 32'(sel_s1) == i;
		assign ctl.upd = adv && !is_read;
		assign ctl.clr = adv && is_read && sel_hit;

		if (i < tgc_pkg::NUM_READINGS) begin : g_read
			assign ctl.touch = raw_s1[i] < cfg_q.touch_threshold;
		end else begin : g_blank
			assign ctl.touch = 1'b0;
		end

		tgc_zone u_zone (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.now_ms  (now_s1),
			.cfg     (cfg_q),
			.pending (pend[i])
		);
	end

	always_comb begin
		read_ev = tgc_pkg::EV_NONE;
		for (int i = 0; i < tgc_pkg::NUM_ZONES; i++) begin
			if (32'(sel_s1) == i) begin
				read_ev = pend[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_read) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_read) begin
			event_q <= read_ev;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.event_res = event_q;

endmodule

// ===== sv/tgc_zone.sv =====
// ----------------------------------------------------------------------------
// tgc_zone
// Per-zone press tracker: detects press and release, classifies a release as
// hold, tap or pet, and keeps the zone's pending event.
// ----------------------------------------------------------------------------
module tgc_zone (
	input  logic               clk,
	input  logic               arst_n,
	input  tgc_pkg::zone_ctl_t ctl,
	input  logic [31:0]        now_ms,
	input  tgc_pkg::cfg_t      cfg,
	output logic [1:0]         pending
);

	logic        touched_q;
	logic [31:0] press_start_q;
	logic [3:0]  tap_run_q;
	logic [31:0] last_tap_q;
	logic [1:0]  pending_q;

	logic [31:0] held;
	logic [31:0] gap;
	logic        is_hold;
	logic        chained;
	logic [3:0]  run_inc;
	logic [3:0]  run_new;
	logic        is_pet;

	always_comb begin
		held    = now_ms - press_start_q;
		gap     = now_ms - last_tap_q;
		is_hold = held > {16'd0, cfg.hold_time_ms};
		chained = gap < {16'd0, cfg.pet_window_ms};
		run_inc = (tap_run_q == tgc_pkg::RUN_MAX) ? tap_run_q : tap_run_q + 4'd1;
		run_new = chained ? run_inc : 4'd1;
		is_pet  = run_new >= cfg.pet_tap_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q     <= 1'b0;
			press_start_q <= '0;
			tap_run_q     <= '0;
			last_tap_q    <= '0;
			pending_q     <= tgc_pkg::EV_NONE;
		end else if (ctl.upd) begin
			if (ctl.touch && !touched_q) begin
				press_start_q <= now_ms;
				touched_q     <= 1'b1;
			end else if (!ctl.touch && touched_q) begin
				touched_q <= 1'b0;
				if (is_hold) begin
					pending_q <= tgc_pkg::EV_HOLD;
					tap_run_q <= '0;
				end else begin
					last_tap_q <= now_ms;
					pending_q  <= is_pet ? tgc_pkg::EV_PET : tgc_pkg::EV_TAP;
					tap_run_q  <= is_pet ? 4'd0 : run_new;
				end
			end
		end else if (ctl.clr) begin
			pending_q <= tgc_pkg::EV_NONE;
		end
	end

	assign pending = pending_q;

endmodule

// ===== sv/tgc_checker.sv =====
// ----------------------------------------------------------------------------
// tgc_checker
// Port-level checks of the touch gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tgc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       item_cmd,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_event
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_event))
		else $error("result dropped or changed while stalled");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_valid && item_ready && item_cmd, 2))
		else $error("result without a read transaction two cycles earlier");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("input stalled while the output register is empty");

endmodule

bind touch_gesture_classifier_top tgc_checker u_tgc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_cmd   (item.cmd),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_event  (result.event_res)
);
